/* rtl/tbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_pkg: shared types and constants of the trigger byte responder
// Register indexes, item and result codes, sequencer steps, the register
// bundle and the result record passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
package tbr_pkg;

    localparam int BYTE_W       = 8;
    localparam int FIELD_TIME_W = 24;
    localparam int COUNT_W      = 4;
    localparam int GAP_W        = 8;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int MODE_W       = 2;

    // Results produced by one item never exceed this; later ones are dropped.
    localparam int RESULT_CAP   = 17;
    localparam int RES_CNT_W    = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_SET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLY_BYTES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLY_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_WINDOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_GAP       = 3'd6;

    // Register reset values.
    localparam logic [CFG_W-1:0]        RST_TRIGGER_SET    = 64'd0;
    localparam logic [COUNT_W-1:0]      RST_TRIGGER_COUNT  = 4'd1;
    localparam logic [CFG_W-1:0]        RST_REPLY_BYTES    = 64'd0;
    localparam logic [COUNT_W-1:0]      RST_REPLY_COUNT    = 4'd1;
    localparam logic [FIELD_TIME_W-1:0] RST_WAIT_LIMIT     = 24'd1000;
    localparam logic [FIELD_TIME_W-1:0] RST_CAPTURE_WINDOW = 24'd0;
    localparam logic [GAP_W-1:0]        RST_IDLE_GAP       = 8'd10;

    localparam logic [FIELD_TIME_W-1:0] FIELD_TIME_MAX = 24'hFFFFFF;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_ARM  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BYTE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    typedef enum logic [2:0] {
        KIND_TX      = 3'd0,
        KIND_ECHO    = 3'd1,
        KIND_MATCH   = 3'd2,
        KIND_TIMEOUT = 3'd3,
        KIND_CHUNK   = 3'd4,
        KIND_END     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAIT    = 2'd1,
        PH_CAPTURE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IN       = 3'd0,
        ST_REPLY    = 3'd1,
        ST_ECHO     = 3'd2,
        ST_MATCH    = 3'd3,
        ST_TIMEOUT  = 3'd4,
        ST_FLUSH_RD = 3'd5,
        ST_FLUSH    = 3'd6,
        ST_END      = 3'd7
    } step_t;

    // Bit positions of the result plan, in emission order.
    localparam int PLAN_W    = 6;
    localparam int P_REPLY   = 0;
    localparam int P_ECHO    = 1;
    localparam int P_MATCH   = 2;
    localparam int P_TIMEOUT = 3;
    localparam int P_FLUSH   = 4;
    localparam int P_END     = 5;

    typedef struct packed {
        logic [CFG_W-1:0]        trigger_set;
        logic [COUNT_W-1:0]      trigger_count;
        logic [CFG_W-1:0]        reply_bytes;
        logic [COUNT_W-1:0]      reply_count;
        logic [FIELD_TIME_W-1:0] wait_limit;
        logic [FIELD_TIME_W-1:0] capture_window;
        logic [GAP_W-1:0]        idle_gap;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        kind_t                   kind;
        logic [BYTE_W-1:0]       value;
        logic [FIELD_TIME_W-1:0] elapsed;
        logic                    last;
    } result_t;

endpackage

/* rtl/tbr_chunk_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_chunk_ram: capture chunk store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module tbr_chunk_ram #(
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [tbr_pkg::BYTE_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [tbr_pkg::BYTE_W-1:0] rdata
);

    logic [tbr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [tbr_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tbr_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_seq: phase control and result sequencer
// Updates the phase, timers and chunk fill when an item is taken, records
// which results it causes, then emits them in order, one per cycle while taken.
// ----------------------------------------------------------------------------
module tbr_seq #(
    parameter int  MAX_TRIGGERS = 8,
    parameter int  CHUNK_DEPTH  = 16,
    parameter int  TIME_BITS    = 24,
    localparam int AW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tbr_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    input  logic [tbr_pkg::MODE_W-1:0]    in_mode,
    input  logic [tbr_pkg::BYTE_W-1:0]    in_byte,
    output logic                          in_ready,
    input  logic                          take,
    output tbr_pkg::result_t              res,
    output logic                          ram_we,
    output logic [AW-1:0]                 ram_waddr,
    output logic [tbr_pkg::BYTE_W-1:0]    ram_wdata,
    output logic                          ram_re,
    output logic [AW-1:0]                 ram_raddr,
    input  logic [tbr_pkg::BYTE_W-1:0]    ram_rdata
);

    localparam int FW = $clog2(CHUNK_DEPTH + 1);
    localparam int EW = (TIME_BITS > tbr_pkg::FIELD_TIME_W) ? TIME_BITS : tbr_pkg::FIELD_TIME_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    function automatic logic [tbr_pkg::COUNT_W-1:0] clamp_count(
        input logic [tbr_pkg::COUNT_W-1:0] c);
        return (c > tbr_pkg::COUNT_W'(MAX_TRIGGERS)) ? tbr_pkg::COUNT_W'(MAX_TRIGGERS) : c;
    endfunction

    function automatic logic [tbr_pkg::FIELD_TIME_W-1:0] sat_time(input logic [TIME_BITS-1:0] t);
        logic [EW-1:0] x;
        x = EW'(t);
        return (x > EW'(tbr_pkg::FIELD_TIME_MAX)) ? tbr_pkg::FIELD_TIME_MAX
                                                   : x[tbr_pkg::FIELD_TIME_W-1:0];
    endfunction

    function automatic tbr_pkg::step_t first_step(input logic [tbr_pkg::PLAN_W-1:0] en);
        if (en[tbr_pkg::P_REPLY])   return tbr_pkg::ST_REPLY;
        if (en[tbr_pkg::P_ECHO])    return tbr_pkg::ST_ECHO;
        if (en[tbr_pkg::P_MATCH])   return tbr_pkg::ST_MATCH;
        if (en[tbr_pkg::P_TIMEOUT]) return tbr_pkg::ST_TIMEOUT;
        if (en[tbr_pkg::P_FLUSH])   return tbr_pkg::ST_FLUSH_RD;
        if (en[tbr_pkg::P_END])     return tbr_pkg::ST_END;
        return tbr_pkg::ST_IN;
    endfunction

    // Plan positions that come after the given step.
    function automatic logic [tbr_pkg::PLAN_W-1:0] later_mask(input tbr_pkg::step_t s);
        logic [tbr_pkg::PLAN_W-1:0] m;
        m = '0;
        case (s)
            tbr_pkg::ST_REPLY:    m = 6'b111110;
            tbr_pkg::ST_ECHO:     m = 6'b111100;
            tbr_pkg::ST_MATCH:    m = 6'b111000;
            tbr_pkg::ST_TIMEOUT:  m = 6'b110000;
            tbr_pkg::ST_FLUSH_RD: m = 6'b100000;
            tbr_pkg::ST_FLUSH:    m = 6'b100000;
            default:              m = '0;
        endcase
        return m;
    endfunction

    tbr_pkg::step_t  state_reg, state_next;
    tbr_pkg::phase_t phase_reg, phase_next;
    logic [TIME_BITS-1:0]               el_reg, el_next;
    logic [TIME_BITS-1:0]               lbt_reg, lbt_next;
    logic [FW-1:0]                      fill_reg, fill_next;
    logic [tbr_pkg::PLAN_W-1:0]         plan_reg, plan_next;
    logic [tbr_pkg::BYTE_W-1:0]         byte_reg;
    logic [tbr_pkg::FIELD_TIME_W-1:0]   snap_reg, snap_next;
    logic [FW-1:0]                      nflush_reg, nflush_next;
    logic [FW-1:0]                      idx_reg, idx_next;
    logic [tbr_pkg::COUNT_W-1:0]        k_reg, k_next;
    logic [tbr_pkg::RES_CNT_W-1:0]      cnt_reg, cnt_next;

    logic                               accept;
    logic                               hit;
    logic                               start_cap;
    logic                               wr_en;
    logic [tbr_pkg::COUNT_W-1:0]        tc;
    logic [tbr_pkg::COUNT_W-1:0]        rc;
    logic [TIME_BITS-1:0]               el_inc;
    logic [TIME_BITS-1:0]               gap_diff;
    logic [tbr_pkg::PLAN_W-1:0]         plan_new;
    logic                               emit;
    logic                               more_in_step;
    logic                               cap_hit;
    logic                               last_res;
    tbr_pkg::step_t                     after_step;
    logic [FW-1:0]                      idx_inc;
    logic [tbr_pkg::COUNT_W-1:0]        k_inc;

    assign in_ready = (state_reg == tbr_pkg::ST_IN);
    assign accept   = in_valid && in_ready;
    assign tc       = clamp_count(cfg.trigger_count);
    assign rc       = clamp_count(cfg.reply_count);
    assign el_inc   = (el_reg == TIME_MAX) ? el_reg : el_reg + TIME_BITS'(1);
    assign gap_diff = el_inc - lbt_reg;
    assign idx_inc  = idx_reg + FW'(1);
    assign k_inc    = k_reg + tbr_pkg::COUNT_W'(1);

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < MAX_TRIGGERS; i++)
        begin
            if ((tbr_pkg::COUNT_W'(i) < tc) &&
                (cfg.trigger_set[8*i +: 8] == in_byte))
            begin
                hit = 1'b1;
            end
        end
    end

    // Phase and timer update for an accepted item, and the results it causes.
    always_comb
    begin
        phase_next  = phase_reg;
        el_next     = el_reg;
        lbt_next    = lbt_reg;
        fill_next   = fill_reg;
        snap_next   = snap_reg;
        nflush_next = nflush_reg;
        plan_new    = '0;
        start_cap   = 1'b0;
        wr_en       = 1'b0;
        if (accept)
        begin
            case (in_mode)
                tbr_pkg::MODE_ARM:
                begin
                    phase_next = tbr_pkg::PH_WAIT;
                    el_next    = '0;
                    lbt_next   = '0;
                    fill_next  = '0;
                    if (cfg.wait_limit == '0)
                    begin
                        plan_new[tbr_pkg::P_TIMEOUT] = 1'b1;
                        start_cap                    = 1'b1;
                    end
                end
                tbr_pkg::MODE_BYTE:
                begin
                    if (phase_reg == tbr_pkg::PH_WAIT)
                    begin
                        plan_new[tbr_pkg::P_ECHO] = 1'b1;
                        snap_next                 = sat_time(el_reg);
                        if (hit)
                        begin
                            plan_new[tbr_pkg::P_REPLY] = (rc != '0);
                            plan_new[tbr_pkg::P_MATCH] = 1'b1;
                            start_cap                  = 1'b1;
                        end
                    end
                    else if (phase_reg == tbr_pkg::PH_CAPTURE)
                    begin
                        wr_en     = 1'b1;
                        lbt_next  = el_reg;
                        snap_next = sat_time(el_reg);
                        if ((fill_reg + FW'(1) == FW'(CHUNK_DEPTH)) || (cfg.idle_gap == '0))
                        begin
                            plan_new[tbr_pkg::P_FLUSH] = 1'b1;
                            nflush_next                = fill_reg + FW'(1);
                            fill_next                  = '0;
                        end
                        else
                        begin
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                end
                tbr_pkg::MODE_TICK:
                begin
                    if (phase_reg == tbr_pkg::PH_WAIT)
                    begin
                        el_next = el_inc;
                        if (EW'(el_inc) >= EW'(cfg.wait_limit))
                        begin
                            plan_new[tbr_pkg::P_TIMEOUT] = 1'b1;
                            start_cap                    = 1'b1;
                        end
                    end
                    else if (phase_reg == tbr_pkg::PH_CAPTURE)
                    begin
                        el_next   = el_inc;
                        snap_next = sat_time(el_inc);
                        if (EW'(el_inc) >= EW'(cfg.capture_window))
                        begin
                            plan_new[tbr_pkg::P_FLUSH] = (fill_reg != '0);
                            plan_new[tbr_pkg::P_END]   = 1'b1;
                            nflush_next                = fill_reg;
                            fill_next                  = '0;
                            phase_next                 = tbr_pkg::PH_IDLE;
                        end
                        else if ((fill_reg != '0) && (EW'(gap_diff) >= EW'(cfg.idle_gap)))
                        begin
                            plan_new[tbr_pkg::P_FLUSH] = 1'b1;
                            nflush_next                = fill_reg;
                            fill_next                  = '0;
                        end
                    end
                end
                default:
                begin
                    plan_new = '0;
                end
            endcase
            if (start_cap)
            begin
                phase_next = tbr_pkg::PH_CAPTURE;
                el_next    = '0;
                lbt_next   = '0;
                fill_next  = '0;
                if (cfg.capture_window == '0)
                begin
                    plan_new[tbr_pkg::P_END] = 1'b1;
                    phase_next               = tbr_pkg::PH_IDLE;
                end
            end
        end
        plan_next = accept ? plan_new : plan_reg;
    end

    // Sequencer outputs.
    always_comb
    begin
        res.valid    = 1'b0;
        res.kind     = tbr_pkg::KIND_TX;
        res.value    = '0;
        res.elapsed  = '0;
        more_in_step = 1'b0;
        unique case (state_reg)
            tbr_pkg::ST_IN, tbr_pkg::ST_FLUSH_RD:
            begin
                res.valid = 1'b0;
            end
            tbr_pkg::ST_REPLY:
            begin
                res.valid    = 1'b1;
                res.kind     = tbr_pkg::KIND_TX;
                res.value    = cfg.reply_bytes[{k_reg[2:0], 3'b000} +: 8];
                more_in_step = (k_inc < rc);
            end
            tbr_pkg::ST_ECHO:
            begin
                res.valid   = 1'b1;
                res.kind    = tbr_pkg::KIND_ECHO;
                res.value   = byte_reg;
                res.elapsed = snap_reg;
            end
            tbr_pkg::ST_MATCH:
            begin
                res.valid = 1'b1;
                res.kind  = tbr_pkg::KIND_MATCH;
                res.value = byte_reg;
            end
            tbr_pkg::ST_TIMEOUT:
            begin
                res.valid = 1'b1;
                res.kind  = tbr_pkg::KIND_TIMEOUT;
            end
            tbr_pkg::ST_FLUSH:
            begin
                res.valid    = 1'b1;
                res.kind     = tbr_pkg::KIND_CHUNK;
                res.value    = ram_rdata;
                res.elapsed  = snap_reg;
                more_in_step = (idx_inc < nflush_reg);
            end
            tbr_pkg::ST_END:
            begin
                res.valid = 1'b1;
                res.kind  = tbr_pkg::KIND_END;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
        emit       = res.valid && take;
        cap_hit    = (cnt_reg == tbr_pkg::RES_CNT_W'(tbr_pkg::RESULT_CAP - 1));
        after_step = first_step(plan_reg & later_mask(state_reg));
        last_res   = cap_hit || (!more_in_step && (after_step == tbr_pkg::ST_IN));
        res.last   = last_res;

        ram_we    = wr_en;
        ram_waddr = fill_reg[AW-1:0];
        ram_wdata = in_byte;
        ram_re    = (state_reg == tbr_pkg::ST_FLUSH_RD) ||
                    ((state_reg == tbr_pkg::ST_FLUSH) && emit && more_in_step && !cap_hit);
        ram_raddr = (state_reg == tbr_pkg::ST_FLUSH_RD) ? idx_reg[AW-1:0] : idx_inc[AW-1:0];
    end

    // Sequencer next state and counters.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            tbr_pkg::ST_IN:
            begin
                if (accept)
                begin
                    state_next = first_step(plan_new);
                    idx_next   = '0;
                    k_next     = '0;
                    cnt_next   = '0;
                end
            end
            tbr_pkg::ST_FLUSH_RD:
            begin
                state_next = tbr_pkg::ST_FLUSH;
            end
            default:
            begin
                if (emit)
                begin
                    cnt_next = cnt_reg + tbr_pkg::RES_CNT_W'(1);
                    if (state_reg == tbr_pkg::ST_REPLY)
                    begin
                        k_next = k_inc;
                    end
                    if (state_reg == tbr_pkg::ST_FLUSH)
                    begin
                        idx_next = idx_inc;
                    end
                    if (last_res)
                    begin
                        state_next = tbr_pkg::ST_IN;
                    end
                    else if (!more_in_step)
                    begin
                        state_next = after_step;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbr_pkg::ST_IN;
            phase_reg <= tbr_pkg::PH_IDLE;
            el_reg    <= '0;
            lbt_reg   <= '0;
            fill_reg  <= '0;
            plan_reg  <= '0;
            idx_reg   <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            el_reg    <= el_next;
            lbt_reg   <= lbt_next;
            fill_reg  <= fill_next;
            plan_reg  <= plan_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
        end
        snap_reg   <= snap_next;
        nflush_reg <= nflush_next;
    end

endmodule

/* rtl/trigger_byte_responder_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trigger_byte_responder_capture: trigger byte responder with post capture
// Path: the first result of an item is registered in the sequencer state,
//   then in the output register; a flush first passes a memory read step.
// Throughput: one result beat per cycle while m_tready is high, but for the
//   read step of a flush; an item holds the input until its final result.
// Reset: rst_n is asynchronous; registers, phase and timers return to their
//   reset values at once. The chunk memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
//
// The block watches a stream of items: arm events, received UART bytes and
// millisecond ticks. After an arm it waits for one of the configured trigger
// bytes, echoing each byte with the time since arming. A trigger causes the
// canned reply bytes, the echo and a match report; the wait limit running out
// causes a timeout report. Either starts the capture window, in which bytes
// are gathered in the chunk memory and flushed as chunk beats when the chunk
// is full, after a quiet gap, or when the window closes, followed by an end
// report.
//
// The sequencer updates all phase state in the cycle the item is taken and
// records a plan of the results that the item causes. It then walks the plan
// one result a cycle as the output register takes them. Chunk bytes come out
// of a synchronous memory; the read of the next entry is issued while the
// current one is presented, so a flush runs at full rate after the first read.
// Chunk bytes are only written when an item is taken and only read while the
// input is held, so reads and writes of one entry never overlap.
//
// An output register separates the sequencer from the result stream, so the
// next item is taken while the final result of the previous one still waits.
module trigger_byte_responder_capture #(
    parameter int MAX_TRIGGERS = 8,
    parameter int CHUNK_DEPTH  = 16,
    parameter int TIME_BITS    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // Item stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_tuser,    // [1:0] mode
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] value, [31:8] elapsed_ms
    output logic [2:0]  m_tuser,    // [2:0] kind
    output logic        m_tlast,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int AW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;

    tbr_pkg::cfg_t    cfg_reg, cfg_next;
    tbr_pkg::result_t res;

    logic                               take;
    logic                               out_valid_reg, out_valid_next;
    tbr_pkg::kind_t                     out_kind_reg;
    logic [tbr_pkg::BYTE_W-1:0]         out_value_reg;
    logic [tbr_pkg::FIELD_TIME_W-1:0]   out_elapsed_reg;
    logic                               out_last_reg;

    logic                               ram_we;
    logic [AW-1:0]                      ram_waddr;
    logic [tbr_pkg::BYTE_W-1:0]         ram_wdata;
    logic                               ram_re;
    logic [AW-1:0]                      ram_raddr;
    logic [tbr_pkg::BYTE_W-1:0]         ram_rdata;

    // Register write decode. Indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tbr_pkg::REG_TRIGGER_SET:    cfg_next.trigger_set    = cfg_data;
                tbr_pkg::REG_TRIGGER_COUNT:  cfg_next.trigger_count  = cfg_data[3:0];
                tbr_pkg::REG_REPLY_BYTES:    cfg_next.reply_bytes    = cfg_data;
                tbr_pkg::REG_REPLY_COUNT:    cfg_next.reply_count    = cfg_data[3:0];
                tbr_pkg::REG_WAIT_LIMIT:     cfg_next.wait_limit     = cfg_data[23:0];
                tbr_pkg::REG_CAPTURE_WINDOW: cfg_next.capture_window = cfg_data[23:0];
                tbr_pkg::REG_IDLE_GAP:       cfg_next.idle_gap       = cfg_data[7:0];
                default:                     cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_set    <= tbr_pkg::RST_TRIGGER_SET;
            cfg_reg.trigger_count  <= tbr_pkg::RST_TRIGGER_COUNT;
            cfg_reg.reply_bytes    <= tbr_pkg::RST_REPLY_BYTES;
            cfg_reg.reply_count    <= tbr_pkg::RST_REPLY_COUNT;
            cfg_reg.wait_limit     <= tbr_pkg::RST_WAIT_LIMIT;
            cfg_reg.capture_window <= tbr_pkg::RST_CAPTURE_WINDOW;
            cfg_reg.idle_gap       <= tbr_pkg::RST_IDLE_GAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tbr_seq #(
        .MAX_TRIGGERS (MAX_TRIGGERS),
        .CHUNK_DEPTH  (CHUNK_DEPTH),
        .TIME_BITS    (TIME_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .take      (take),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tbr_chunk_ram #(
        .DEPTH (CHUNK_DEPTH)
    ) u_chunk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: loads a result when empty or when its beat leaves.
    assign take = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid && take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && take)
        begin
            out_kind_reg    <= res.kind;
            out_value_reg   <= res.value;
            out_elapsed_reg <= res.elapsed;
            out_last_reg    <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_elapsed_reg, out_value_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // The sequencer never offers a result while it is free to take an item.
    a_no_result_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !s_tready)
        else $error("result offered while the item input is ready");

    // A result that the output register cannot take is held unchanged.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !take |=> res.valid && $stable(res))
        else $error("pending result changed before it was taken");

    // An item of the unused mode causes no result and frees the input at once.
    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == tbr_pkg::MODE_NONE) |=> s_tready)
        else $error("unused mode item kept the input busy");

    // Handing over the final result of an item frees the input.
    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last && take |=> s_tready)
        else $error("input still busy after the final result");

endmodule
